@@ hdl/rcam_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the axis autolearn mapper.
package rcam_pkg;

    localparam int DEF_NUM_AXES     = 6;
    localparam int DEF_NUM_CONTROLS = 10;
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_NUM_BUTTONS  = 32;

    localparam int MAX_AXES     = 8;
    localparam int MAX_CONTROLS = 16;

    localparam logic [15:0] THRESH_RESET = 16'd15000;
    localparam logic [15:0] AXIS_FULL    = 16'hFFFF;
    localparam logic [10:0] CH_LOW       = 11'd172;
    localparam logic [10:0] CH_HIGH      = 11'd1811;
    localparam logic [10:0] CH_MID       = 11'd992;
    localparam logic [10:0] CH_SPAN      = CH_HIGH - CH_LOW;

    typedef enum logic [2:0] {
        CMD_SAMPLE = 3'd0,
        CMD_START  = 3'd1,
        CMD_ACCEPT = 3'd2,
        CMD_SKIP   = 3'd3,
        CMD_CANCEL = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_CAL  = 3'b010,
        MODE_DONE = 3'b100
    } t_mode;

    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_CAL  = 2'd1;
    localparam logic [1:0] MODE_CODE_DONE = 2'd2;

    localparam logic [1:0] OUTC_NONE   = 2'd0;
    localparam logic [1:0] OUTC_AXIS   = 2'd1;
    localparam logic [1:0] OUTC_BUTTON = 2'd2;

    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] axis_x;
        logic [15:0] axis_y;
        logic [15:0] axis_z;
        logic [15:0] axis_r;
        logic [15:0] axis_u;
        logic [15:0] axis_v;
        logic [31:0] buttons;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel;
        logic [10:0] value;
        logic [1:0]  step_outcome;
        logic [4:0]  source_index;
        logic [1:0]  mode;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       is_axis;
        logic [4:0] index;
    } t_map_entry;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_CAL:  c = MODE_CODE_CAL;
            MODE_DONE: c = MODE_CODE_DONE;
            default:   c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

    // 172 + raw * 1639 / 65535, with the divide done as shift plus one correction
    function automatic logic [10:0] scale_axis(input logic [15:0] raw);
        logic [26:0] prod;
        logic [10:0] quo;
        logic [16:0] rem;
        prod = 27'(raw) * 27'(CH_SPAN);
        quo  = prod[26:16];
        rem  = {1'b0, prod[15:0]} + 17'(quo);
        if (rem >= 17'(AXIS_FULL)) begin
            quo = quo + 11'd1;
        end
        return CH_LOW + quo;
    endfunction

endpackage

@@ hdl/rc_axis_autolearn_mapper_unit.sv @@
`timescale 1ns / 1ps
// Top level of the axis autolearn mapper: learns controls, then maps samples to channels.
//
// Requests pass through a one-deep input register into combinational decode and state
// update, and results leave from one output register. A new request can enter every
// cycle while the one ahead does not stall. A sample in calibrated mode gives NUM_CHANNELS
// results (16 by default), one per cycle unless the output stalls, and holds the input
// register until the last is issued. Output stalls back up to the input.
// The detect threshold write port is always ready; write it only while the block is idle.
module rc_axis_autolearn_mapper_unit
    import rcam_pkg::*;
#(
    parameter int NUM_AXES     = DEF_NUM_AXES,
    parameter int NUM_CONTROLS = DEF_NUM_CONTROLS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int NUM_BUTTONS  = DEF_NUM_BUTTONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam logic [31:0] BTN_MASK = 32'((64'd1 << NUM_BUTTONS) - 64'd1);
    localparam logic [3:0]  LAST_CH  = 4'(NUM_CHANNELS - 1);

    // control state
    logic                    r_in_valid;
    logic                    r_out_valid;
    t_mode                   r_mode,  n_mode;
    logic [3:0]              r_ctl,   n_ctl;
    logic [3:0]              r_chan;
    logic [MAX_CONTROLS-1:0] r_map_vld;
    logic [15:0]             r_thresh;

    // payload
    t_in_item                r_in,    n_in;
    t_out_item               r_out,   n_out;
    t_map_entry              r_map [MAX_CONTROLS];
    logic [15:0]             r_base [NUM_AXES];
    logic [15:0]             r_peak [NUM_AXES];
    logic [15:0]             n_peak [NUM_AXES];
    logic [31:0]             r_base_btn;
    logic [31:0]             r_chg_btn;

    logic [15:0] in_axes [MAX_AXES];
    logic        is_sample, is_start, is_step, is_accept, is_cancel;
    logic        emit_chan, emit_rep, produces, out_free, fire, last_step, item_done;
    logic        take_base, upd_cal, clr_map, map_we;
    logic        axis_hit, btn_hit;
    logic [2:0]  axis_idx;
    logic [4:0]  btn_idx;
    logic [15:0] best_val;
    logic [1:0]  outcome;
    logic [4:0]  src;
    logic [10:0] ch_val;
    t_map_entry  ch_ent;

    assign in_axes[0] = r_in.axis_x;
    assign in_axes[1] = r_in.axis_y;
    assign in_axes[2] = r_in.axis_z;
    assign in_axes[3] = r_in.axis_r;
    assign in_axes[4] = r_in.axis_u;
    assign in_axes[5] = r_in.axis_v;
    assign in_axes[6] = '0;
    assign in_axes[7] = '0;

    // buttons above NUM_BUTTONS never count
    always_comb begin
        n_in         = i_in_data;
        n_in.buttons = i_in_data.buttons & BTN_MASK;
    end

    always_comb begin
        is_sample = 1'b0;
        is_start  = 1'b0;
        is_step   = 1'b0;
        is_accept = 1'b0;
        is_cancel = 1'b0;
        case (r_in.command)
            CMD_SAMPLE: is_sample = 1'b1;
            CMD_START:  is_start  = 1'b1;
            CMD_ACCEPT: begin
                is_step   = 1'b1;
                is_accept = 1'b1;
            end
            CMD_SKIP:   is_step   = 1'b1;
            CMD_CANCEL: is_cancel = 1'b1;
            default:    ;
        endcase
    end

    assign emit_chan = is_sample && (r_mode == MODE_DONE);
    assign emit_rep  = is_step && (r_mode == MODE_CAL);
    assign produces  = emit_chan || emit_rep;
    assign out_free  = !r_out_valid || i_out_ready;
    assign fire      = r_in_valid && (!produces || out_free);
    assign last_step = !emit_chan || (r_chan == LAST_CH);
    assign item_done = fire && last_step;
    assign o_in_ready  = !r_in_valid || item_done;
    assign o_cfg_ready = 1'b1;

    // largest peak above threshold, lowest axis on a tie
    always_comb begin
        axis_hit = 1'b0;
        axis_idx = '0;
        best_val = r_thresh;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r_peak[i] > best_val) begin
                best_val = r_peak[i];
                axis_idx = 3'(i);
                axis_hit = 1'b1;
            end
        end
    end

    always_comb begin
        btn_hit = 1'b0;
        btn_idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (r_chg_btn[i]) begin
                btn_hit = 1'b1;
                btn_idx = 5'(i);
            end
        end
    end

    always_comb begin
        outcome = OUTC_NONE;
        src     = '0;
        if (is_accept) begin
            if (axis_hit) begin
                outcome = OUTC_AXIS;
                src     = {2'b00, axis_idx};
            end else if (btn_hit) begin
                outcome = OUTC_BUTTON;
                src     = btn_idx;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            logic [15:0] d;
            d = (in_axes[i] >= r_base[i]) ? (in_axes[i] - r_base[i])
                                          : (r_base[i] - in_axes[i]);
            n_peak[i] = (d > r_peak[i]) ? d : r_peak[i];
        end
    end

    // next control state, applied when the request completes
    always_comb begin
        n_mode    = r_mode;
        n_ctl     = r_ctl;
        take_base = 1'b0;
        upd_cal   = 1'b0;
        clr_map   = 1'b0;
        map_we    = 1'b0;
        if (is_start) begin
            n_mode    = MODE_CAL;
            n_ctl     = '0;
            take_base = 1'b1;
            clr_map   = 1'b1;
        end else if (is_cancel) begin
            n_mode = MODE_IDLE;
        end else if (is_sample && r_mode == MODE_CAL) begin
            upd_cal = 1'b1;
        end else if (emit_rep) begin
            map_we = (outcome != OUTC_NONE);
            if (5'(r_ctl) + 5'd1 >= 5'(NUM_CONTROLS)) begin
                n_mode = MODE_DONE;
                n_ctl  = '0;
            end else begin
                n_ctl     = r_ctl + 4'd1;
                take_base = 1'b1;
            end
        end
    end

    // channel value for the channel being emitted
    always_comb begin
        ch_ent = r_map[r_chan];
        ch_val = (r_chan == 4'd2) ? CH_LOW : CH_MID;
        if ((5'(r_chan) < 5'(NUM_CONTROLS)) && r_map_vld[r_chan]) begin
            if (ch_ent.is_axis) begin
                ch_val = scale_axis(in_axes[ch_ent.index[2:0]]);
            end else begin
                ch_val = r_in.buttons[ch_ent.index] ? CH_HIGH : CH_LOW;
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (emit_chan) begin
            n_out.kind    = KIND_CHANNEL;
            n_out.channel = r_chan;
            n_out.value   = ch_val;
            n_out.mode    = MODE_CODE_DONE;
            n_out.last    = last_step;
        end else begin
            n_out.kind         = KIND_REPORT;
            n_out.channel      = r_ctl;
            n_out.step_outcome = outcome;
            n_out.source_index = src;
            n_out.mode         = mode_code(n_mode);
            n_out.last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_ctl       <= '0;
            r_chan      <= '0;
            r_map_vld   <= '0;
            r_thresh    <= THRESH_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (item_done) begin
                r_in_valid <= 1'b0;
            end
            if (fire && produces) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (item_done) begin
                r_chan <= '0;
            end else if (fire && emit_chan) begin
                r_chan <= r_chan + 4'd1;
            end
            if (item_done) begin
                r_mode <= n_mode;
                r_ctl  <= n_ctl;
                if (clr_map) begin
                    r_map_vld <= '0;
                end else if (map_we) begin
                    r_map_vld[r_ctl] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= n_in;
        end
        if (fire && produces) begin
            r_out <= n_out;
        end
        if (item_done) begin
            if (map_we) begin
                r_map[r_ctl] <= t_map_entry'{is_axis: (outcome == OUTC_AXIS), index: src};
            end
            if (take_base) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_base[i] <= in_axes[i];
                    r_peak[i] <= '0;
                end
                r_base_btn <= r_in.buttons;
                r_chg_btn  <= '0;
            end else if (upd_cal) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_peak[i] <= n_peak[i];
                end
                r_chg_btn <= r_chg_btn | ((r_in.buttons ^ r_base_btn) & BTN_MASK);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/rcam_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the axis autolearn mapper, bound to the top level.
module rcam_chk
    import rcam_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a step report is a single result with no channel value
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_REPORT
        |-> o_out_data.last && o_out_data.value == '0)
        else $error("malformed step report");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_CHANNEL
        |-> o_out_data.value >= CH_LOW && o_out_data.value <= CH_HIGH
            && o_out_data.step_outcome == OUTC_NONE
            && o_out_data.mode == MODE_CODE_DONE)
        else $error("channel value out of range");

    // channel burst runs without gaps in channel order
    a_chan_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.kind == KIND_CHANNEL && !o_out_data.last
        |=> o_out_valid && o_out_data.kind == KIND_CHANNEL
            && o_out_data.channel == $past(o_out_data.channel) + 4'd1)
        else $error("channel burst broken");

endmodule

bind rc_axis_autolearn_mapper_unit rcam_chk u_rcam_chk (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the axis autolearn mapper: random and directed requests checked against a bench-side model.
module tb_top;
    import rcam_pkg::*;

    localparam int NUM_AX      = DEF_NUM_AXES;
    localparam int NUM_CTL     = DEF_NUM_CONTROLS;
    localparam int NUM_CH      = DEF_NUM_CHANNELS;
    localparam int NUM_BTN     = DEF_NUM_BUTTONS;
    localparam int LOW_IDLE_CH = 2;          // channel that rests low when unmapped
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 32;
    localparam int SETTLE_CYC  = 8;
    localparam logic [2:0]  CMD_TOP = 3'd7;  // highest encodable command, unused
    localparam logic [15:0] MID_AX  = 16'd32768;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    rc_axis_autolearn_mapper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_in_item  req_backlog [$];
    t_out_item due_results [$];
    t_out_item got_item;
    t_out_item want_item;
    int        fail_count = 0;
    int        queued_count = 0;
    int        cycle_count = 0;
    logic      steady = 1'b0;

    // bench copy of the mapper state
    logic [15:0] detect_thr;
    logic [1:0]  mapper_mode;
    int          ctl_idx;
    logic [15:0] rest_axes [NUM_AX];
    logic [31:0] rest_btns;
    logic [15:0] peak_dev [NUM_AX];
    logic [31:0] moved_btns;
    logic        map_ok [NUM_CTL];
    logic        map_is_axis [NUM_CTL];
    logic [4:0]  map_src [NUM_CTL];

    function automatic void clear_mapper_model();
        detect_thr  = THRESH_RESET;
        mapper_mode = MODE_CODE_IDLE;
        ctl_idx     = 0;
        rest_btns   = '0;
        moved_btns  = '0;
        for (int i = 0; i < NUM_AX; i++) begin
            rest_axes[i] = '0;
            peak_dev[i]  = '0;
        end
        for (int k = 0; k < NUM_CTL; k++) begin
            map_ok[k]      = 1'b0;
            map_is_axis[k] = 1'b0;
            map_src[k]     = '0;
        end
    endfunction

    function automatic void take_baseline(input logic [15:0] ax [NUM_AX], input logic [31:0] b);
        for (int i = 0; i < NUM_AX; i++) begin
            rest_axes[i] = ax[i];
            peak_dev[i]  = '0;
        end
        rest_btns  = b;
        moved_btns = '0;
    endfunction

    function automatic void push_result(input logic kind, input logic [3:0] ch,
                                        input logic [10:0] val, input logic [1:0] outc,
                                        input logic [4:0] src, input logic last);
        t_out_item res;
        res.kind         = kind;
        res.channel      = ch;
        res.value        = val;
        res.step_outcome = outc;
        res.source_index = src;
        res.mode         = mapper_mode;
        res.last         = last;
        due_results = {due_results, res};
    endfunction

    task automatic compute_mapper_results(input t_in_item r);
        logic [15:0] ax [NUM_AX];
        logic [15:0] dev;
        logic [15:0] best_peak;
        logic [10:0] val;
        logic [1:0]  outc;
        logic [4:0]  src;
        logic [3:0]  ctl;
        int          best;
        int          prod;
        ax[0] = r.axis_x;
        ax[1] = r.axis_y;
        ax[2] = r.axis_z;
        ax[3] = r.axis_r;
        ax[4] = r.axis_u;
        ax[5] = r.axis_v;
        case (r.command)
            CMD_SAMPLE: begin
                if (mapper_mode == MODE_CODE_CAL) begin
                    for (int i = 0; i < NUM_AX; i++) begin
                        dev = (ax[i] >= rest_axes[i]) ? ax[i] - rest_axes[i]
                                                      : rest_axes[i] - ax[i];
                        if (dev > peak_dev[i]) begin
                            peak_dev[i] = dev;
                        end
                    end
                    moved_btns = moved_btns | (r.buttons ^ rest_btns);
                end else if (mapper_mode == MODE_CODE_DONE) begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        val = (ch == LOW_IDLE_CH) ? CH_LOW : CH_MID;
                        if (ch < NUM_CTL && map_ok[ch]) begin
                            if (map_is_axis[ch]) begin
                                prod = int'(ax[map_src[ch]]) * int'(CH_HIGH - CH_LOW);
                                val  = CH_LOW + 11'(prod / int'(AXIS_FULL));
                            end else begin
                                val = r.buttons[map_src[ch]] ? CH_HIGH : CH_LOW;
                            end
                        end
                        push_result(KIND_CHANNEL, 4'(ch), val, OUTC_NONE, '0, ch == NUM_CH - 1);
                    end
                end
            end
            CMD_START: begin
                for (int k = 0; k < NUM_CTL; k++) begin
                    map_ok[k] = 1'b0;
                end
                ctl_idx     = 0;
                mapper_mode = MODE_CODE_CAL;
                take_baseline(ax, r.buttons);
            end
            CMD_ACCEPT, CMD_SKIP: begin
                if (mapper_mode == MODE_CODE_CAL) begin
                    ctl  = 4'(ctl_idx);
                    outc = OUTC_NONE;
                    src  = '0;
                    if (r.command == CMD_ACCEPT) begin
                        best      = -1;
                        best_peak = detect_thr;
                        for (int i = 0; i < NUM_AX; i++) begin
                            if (peak_dev[i] > best_peak) begin
                                best_peak = peak_dev[i];
                                best      = i;
                            end
                        end
                        if (best >= 0) begin
                            outc = OUTC_AXIS;
                            src  = 5'(best);
                        end else begin
                            for (int b = NUM_BTN - 1; b >= 0; b--) begin
                                if (moved_btns[b]) begin
                                    outc = OUTC_BUTTON;
                                    src  = 5'(b);
                                end
                            end
                        end
                        if (outc != OUTC_NONE) begin
                            map_ok[ctl]      = 1'b1;
                            map_is_axis[ctl] = (outc == OUTC_AXIS);
                            map_src[ctl]     = src;
                        end
                    end
                    if (ctl_idx + 1 >= NUM_CTL) begin
                        mapper_mode = MODE_CODE_DONE;
                        ctl_idx     = 0;
                    end else begin
                        ctl_idx = ctl_idx + 1;
                        take_baseline(ax, r.buttons);
                    end
                    push_result(KIND_REPORT, ctl, '0, outc, src, 1'b1);
                end
            end
            CMD_CANCEL: begin
                mapper_mode = MODE_CODE_IDLE;
            end
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // request driver; the model is stepped on every accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_mapper_model();
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                compute_mapper_results(i_in_data);
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the request until taken
            end else if (req_backlog.size() != 0 &&
                         (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= req_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_item = o_out_data;
            if (due_results.size() == 0) begin
                $error("result with nothing due: channel %0d value %0d",
                       got_item.channel, got_item.value);
                fail_count++;
            end else begin
                want_item = due_results.pop_front();
                check_field("kind", want_item.kind, got_item.kind);
                check_field("channel", want_item.channel, got_item.channel);
                check_field("value", want_item.value, got_item.value);
                check_field("step_outcome", want_item.step_outcome, got_item.step_outcome);
                check_field("source_index", want_item.source_index, got_item.source_index);
                check_field("mode", want_item.mode, got_item.mode);
                check_field("last", want_item.last, got_item.last);
            end
        end
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_in_item mk(input logic [2:0] cmd, input logic [15:0] x,
                                    input logic [15:0] y, input logic [15:0] z,
                                    input logic [15:0] r, input logic [15:0] u,
                                    input logic [15:0] v, input logic [31:0] b);
        t_in_item it;
        it.command = cmd;
        it.axis_x  = x;
        it.axis_y  = y;
        it.axis_z  = z;
        it.axis_r  = r;
        it.axis_u  = u;
        it.axis_v  = v;
        it.buttons = b;
        return it;
    endfunction

    function automatic t_in_item at_rest(input logic [2:0] cmd);
        return mk(cmd, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX, '0);
    endfunction

    function automatic t_in_item any_req(input logic [2:0] cmd);
        return mk(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), $urandom);
    endfunction

    function automatic logic [15:0] shift_axis(input logic [15:0] v, input int delta);
        int t;
        t = int'(v) + delta;
        if (t < 0) begin
            t = 0;
        end else if (t > int'(AXIS_FULL)) begin
            t = int'(AXIS_FULL);
        end
        return 16'(t);
    endfunction

    function automatic t_in_item move_axis(input t_in_item it, input int idx, input int delta);
        case (idx)
            0: it.axis_x = shift_axis(it.axis_x, delta);
            1: it.axis_y = shift_axis(it.axis_y, delta);
            2: it.axis_z = shift_axis(it.axis_z, delta);
            3: it.axis_r = shift_axis(it.axis_r, delta);
            4: it.axis_u = shift_axis(it.axis_u, delta);
            default: it.axis_v = shift_axis(it.axis_v, delta);
        endcase
        return it;
    endfunction

    function automatic t_in_item jitter(input t_in_item pose, input logic [2:0] cmd,
                                        input int amt);
        t_in_item it;
        it = pose;
        it.command = cmd;
        for (int i = 0; i < NUM_AX; i++) begin
            it = move_axis(it, i, int'($urandom_range(0, 2 * amt)) - amt);
        end
        return it;
    endfunction

    function automatic void queue_req(input t_in_item it);
        req_backlog = {req_backlog, it};
        queued_count++;
    endfunction

    // one learning pass with random content, plus occasional breakage
    task automatic queue_calibration();
        t_in_item pose;
        t_in_item it;
        int       motion;
        int       pick_ax;
        int       pick_btn;
        int       roll;
        pose = any_req(CMD_START);
        queue_req(jitter(pose, CMD_START, 800));
        for (int c = 0; c < NUM_CTL; c++) begin
            motion   = $urandom_range(0, 2);
            pick_ax  = $urandom_range(0, NUM_AX - 1);
            pick_btn = $urandom_range(0, NUM_BTN - 1);
            repeat ($urandom_range(0, 3)) begin
                it = jitter(pose, CMD_SAMPLE, 800);
                if (motion == 0) begin
                    it = move_axis(it, pick_ax, int'($urandom_range(0, 40000)) *
                                   ($urandom_range(0, 1) ? 1 : -1));
                end else if (motion == 1) begin
                    it.buttons[pick_btn] = ~pose.buttons[pick_btn];
                end
                queue_req(it);
            end
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                queue_req(jitter(pose, CMD_CANCEL, 800));
            end else if (roll < 8) begin
                queue_req(any_req(3'($urandom_range(0, CMD_TOP))));
            end
            queue_req(jitter(pose, ($urandom_range(0, 99) < 85) ? CMD_ACCEPT : CMD_SKIP, 800));
        end
        repeat ($urandom_range(1, 4)) begin
            queue_req(any_req(CMD_SAMPLE));
        end
    endtask

    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (req_backlog.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] thr);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        detect_thr = thr;
    endtask

    task automatic run_random(input int budget);
        int first;
        int roll;
        first = queued_count;
        while (queued_count - first < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                queue_calibration();
            end else if (roll < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    queue_req(any_req(CMD_SAMPLE));
                end
            end else begin
                queue_req(any_req(3'($urandom_range(0, CMD_TOP))));
            end
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle mode: everything but start is dropped
        queue_req(mk(CMD_SAMPLE, '0, '0, '0, '0, '0, '0, '0));
        queue_req(at_rest(CMD_ACCEPT));
        queue_req(at_rest(CMD_SKIP));
        queue_req(mk(CMD_TOP, '1, '1, '1, '1, '1, '1, '1));
        queue_req(at_rest(CMD_CANCEL));
        queue_req(at_rest(CMD_START));
        // z and r tie above threshold, y sits exactly on it: lowest tied axis wins
        queue_req(mk(CMD_SAMPLE, MID_AX, 16'd47768, 16'd12768, 16'd52768, MID_AX, MID_AX,
                     32'h0000_0008));
        queue_req(at_rest(CMD_ACCEPT));
        // no axis above threshold: lowest changed button
        queue_req(mk(CMD_SAMPLE, 16'd47768, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX,
                     32'h0000_0120));
        queue_req(at_rest(CMD_ACCEPT));
        queue_req(at_rest(CMD_SKIP));          // control 2 left unmapped
        queue_req(at_rest(CMD_ACCEPT));        // nothing moved
        queue_req(mk(CMD_SAMPLE, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX, 16'hFFFF,
                     32'h8000_0001));
        queue_req(at_rest(CMD_ACCEPT));
        queue_req(mk(CMD_SAMPLE, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX,
                     32'h8000_0000));
        queue_req(at_rest(CMD_ACCEPT));
        queue_req(mk(CMD_SAMPLE, '0, MID_AX, MID_AX, MID_AX, MID_AX, MID_AX, '0));
        queue_req(at_rest(CMD_ACCEPT));
        queue_req(at_rest(CMD_SKIP));
        queue_req(at_rest(CMD_ACCEPT));
        queue_req(at_rest(CMD_ACCEPT));        // last control: calibrated
        queue_req(mk(CMD_SAMPLE, '0, '0, '0, '0, '0, '0, '0));
        queue_req(mk(CMD_SAMPLE, '1, '1, '1, '1, '1, '1, '1));
        queue_req(at_rest(CMD_START));         // restart from calibrated
        queue_req(at_rest(CMD_CANCEL));
        queue_req(at_rest(CMD_SAMPLE));
        settle();

        write_threshold(16'd0);
        run_random(75);
        write_threshold(16'hFFFF);
        run_random(60);
        @(negedge i_clk);
        steady = 1'b1;
        write_threshold(16'($urandom));
        run_random(80);
        @(negedge i_clk);
        steady = 1'b0;
        write_threshold(THRESH_RESET);
        run_random(80);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
